>>> rtl/gate_dependency_ready_tracker_assert.svh
// Assertion macros for the gate dependency ready tracker.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef GATE_DEPENDENCY_READY_TRACKER_ASSERT_SVH
`define GATE_DEPENDENCY_READY_TRACKER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define GDRT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define GDRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gdrt_pkg.sv
// Shared constants, codes and control structs of the gate dependency ready tracker.
// No dependencies.
package gdrt_pkg;

    // Default sizes.
    localparam int DEF_MAX_GATES  = 1024;
    localparam int DEF_MAX_QUBITS = 64;
    localparam int DEF_KIND_BITS  = 8;

    // Fixed port field widths.
    localparam int REQ_W  = 2;
    localparam int ID_W   = 10;
    localparam int KIND_W = 8;
    localparam int QB_W   = 6;
    localparam int CTL_W  = 7;
    localparam int CNT_W  = 11;
    localparam int ST_W   = 3;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESOLVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACTIVATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESTART  = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD       = 3'd2;
    localparam logic [ST_W-1:0] ST_FINISHED  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_READY = 3'd4;

    // Control qubit code for a single-qubit gate.
    localparam logic [CTL_W-1:0] NO_CONTROL = 7'd64;

    // Ready set operations.
    localparam logic [1:0] RDY_SET     = 2'd0;
    localparam logic [1:0] RDY_CLR     = 2'd1;
    localparam logic [1:0] RDY_ROOT    = 2'd2;
    localparam logic [1:0] RDY_RESTART = 2'd3;

    typedef struct packed {
        logic       req;
        logic [1:0] op;
    } t_rdy_cmd;

    typedef struct packed {
        logic done;
        logic old_bit;
        logic any;
    } t_rdy_sts;

    typedef struct packed {
        logic rd_en;
        logic cc_we;
        logic tc_we;
        logic pg_we;
        logic op_we;
    } t_gs_ctl;

endpackage

>>> rtl/gdrt_gate_store.sv
// Per-gate memories: control child, target child, progress and operands.
// Depends on gdrt_pkg. One shared read address with registered reads, one write port each.
module gdrt_gate_store import gdrt_pkg::*; #(
    parameter int MAX_GATES = DEF_MAX_GATES,
    parameter int KIND_BITS = DEF_KIND_BITS,
    localparam int IW  = $clog2(MAX_GATES),
    localparam int CHW = IW + 1,
    localparam int OPW = 2 + KIND_BITS + 1 + 2 * QB_W
) (
    input  logic           i_clk,
    input  t_gs_ctl        i_ctl,
    input  logic [IW-1:0]  i_raddr,
    input  logic [IW-1:0]  i_cc_waddr,
    input  logic [CHW-1:0] i_cc_wdata,
    input  logic [IW-1:0]  i_tc_waddr,
    input  logic [CHW-1:0] i_tc_wdata,
    input  logic [IW-1:0]  i_pg_waddr,
    input  logic [2:0]     i_pg_wdata,
    input  logic [IW-1:0]  i_op_waddr,
    input  logic [OPW-1:0] i_op_wdata,
    output logic [CHW-1:0] o_cc_rdata,
    output logic [CHW-1:0] o_tc_rdata,
    output logic [2:0]     o_pg_rdata,
    output logic [OPW-1:0] o_op_rdata
);

    logic [CHW-1:0] cc_mem [MAX_GATES];
    logic [CHW-1:0] tc_mem [MAX_GATES];
    logic [2:0]     pg_mem [MAX_GATES];
    logic [OPW-1:0] op_mem [MAX_GATES];

    // Writes.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cc_we) begin
            cc_mem[i_cc_waddr] <= i_cc_wdata;
        end
        if (i_ctl.tc_we) begin
            tc_mem[i_tc_waddr] <= i_tc_wdata;
        end
        if (i_ctl.pg_we) begin
            pg_mem[i_pg_waddr] <= i_pg_wdata;
        end
        if (i_ctl.op_we) begin
            op_mem[i_op_waddr] <= i_op_wdata;
        end
    end

    // Registered reads; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_cc_rdata <= cc_mem[i_raddr];
            o_tc_rdata <= tc_mem[i_raddr];
            o_pg_rdata <= pg_mem[i_raddr];
            o_op_rdata <= op_mem[i_raddr];
        end
    end

endmodule

>>> rtl/gdrt_ready.sv
// Ready set: row memory of 32-bit words with a per-row nonzero summary,
// root-gate copy for restart, ready count and lowest-id search. Depends on gdrt_pkg.
module gdrt_ready import gdrt_pkg::*; #(
    parameter int MAX_GATES = DEF_MAX_GATES,
    localparam int IW = $clog2(MAX_GATES),
    localparam int CW = $clog2(MAX_GATES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rdy_cmd      i_cmd,
    input  logic [IW-1:0] i_id,
    output t_rdy_sts      o_sts,
    output logic [CW-1:0] o_count,
    output logic [IW-1:0] o_first
);

    localparam int NROWS = (MAX_GATES + 31) / 32;
    localparam int RAW   = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int EW    = RAW + 5;

    localparam logic [2:0] Y_IDLE = 3'd0;
    localparam logic [2:0] Y_MOD  = 3'd1;
    localparam logic [2:0] Y_RSRD = 3'd2;
    localparam logic [2:0] Y_RSWR = 3'd3;
    localparam logic [2:0] Y_FIND = 3'd4;
    localparam logic [2:0] Y_FW   = 3'd5;
    localparam logic [2:0] Y_DONE = 3'd6;

    logic [31:0] ready_mem [NROWS];
    logic [31:0] root_mem  [NROWS];

    logic [2:0]       r_state;
    logic [1:0]       r_op;
    logic [RAW-1:0]   r_row;
    logic [4:0]       r_bit;
    logic [RAW-1:0]   r_frow;
    logic [NROWS-1:0] r_sum;
    logic [NROWS-1:0] r_rootv;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rcnt;
    logic [IW-1:0]    r_first;
    logic             r_any;
    logic             r_old;
    logic [31:0]      r_rd_data;
    logic [31:0]      r_root_data;

    logic [EW-1:0]  ext_id;
    logic           rd_en;
    logic [RAW-1:0] rd_addr;
    logic           we;
    logic           root_we;
    logic [31:0]    wdata;
    logic [31:0]    mask;
    logic [31:0]    cur_w;
    logic [31:0]    root_cur;
    logic [31:0]    root_w;
    logic           old_bit;
    logic           root_old;
    logic [RAW-1:0] find_row;
    logic [4:0]     find_bit;

    assign ext_id   = EW'(i_id);
    assign mask     = 32'(1) << r_bit;
    assign cur_w    = r_sum[r_row] ? r_rd_data : '0;
    assign root_cur = r_rootv[r_row] ? r_root_data : '0;
    assign root_w   = root_cur | mask;
    assign old_bit  = cur_w[r_bit];
    assign root_old = root_cur[r_bit];

    // Lowest nonzero row and lowest set bit of the fetched row.
    always_comb begin
        find_row = '0;
        for (int i = NROWS - 1; i >= 0; i--) begin
            if (r_sum[i]) begin
                find_row = RAW'(i);
            end
        end
        find_bit = '0;
        for (int j = 31; j >= 0; j--) begin
            if (r_rd_data[j]) begin
                find_bit = 5'(j);
            end
        end
    end

    // Memory strobes.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_row;
        we      = 1'b0;
        root_we = 1'b0;
        wdata   = cur_w | mask;
        case (r_state)
            Y_IDLE: begin
                if (i_cmd.req) begin
                    rd_en   = 1'b1;
                    rd_addr = (i_cmd.op == RDY_RESTART) ? '0 : ext_id[EW-1:5];
                end
            end
            Y_MOD: begin
                we      = 1'b1;
                root_we = (r_op == RDY_ROOT);
                wdata   = (r_op == RDY_CLR) ? (cur_w & ~mask) : (cur_w | mask);
            end
            Y_RSRD: begin
                rd_en = 1'b1;
            end
            Y_RSWR: begin
                we    = 1'b1;
                wdata = root_cur;
            end
            Y_FIND: begin
                rd_en   = 1'b1;
                rd_addr = find_row;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            ready_mem[r_row] <= wdata;
        end
        if (root_we) begin
            root_mem[r_row] <= root_w;
        end
        if (rd_en) begin
            r_rd_data   <= ready_mem[rd_addr];
            r_root_data <= root_mem[rd_addr];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Y_IDLE;
            r_sum   <= '0;
            r_rootv <= '0;
            r_count <= '0;
            r_rcnt  <= '0;
            r_first <= '0;
            r_any   <= 1'b0;
        end else begin
            case (r_state)
                Y_IDLE: begin
                    if (i_cmd.req) begin
                        r_op    <= i_cmd.op;
                        r_bit   <= ext_id[4:0];
                        if (i_cmd.op == RDY_RESTART) begin
                            r_row   <= '0;
                            r_state <= Y_RSWR;
                        end else begin
                            r_row   <= ext_id[EW-1:5];
                            r_state <= Y_MOD;
                        end
                    end
                end
                Y_MOD: begin
                    r_old        <= old_bit;
                    r_sum[r_row] <= |wdata;
                    if (r_op == RDY_CLR && old_bit) begin
                        r_count <= r_count - CW'(1);
                    end else if (r_op != RDY_CLR && !old_bit) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (r_op == RDY_ROOT) begin
                        r_rootv[r_row] <= 1'b1;
                        if (!root_old) begin
                            r_rcnt <= r_rcnt + CW'(1);
                        end
                    end
                    r_state <= Y_FIND;
                end
                Y_RSRD: begin
                    r_state <= Y_RSWR;
                end
                Y_RSWR: begin
                    r_sum[r_row] <= |root_cur;
                    if (r_row == RAW'(NROWS - 1)) begin
                        r_count <= r_rcnt;
                        r_state <= Y_FIND;
                    end else begin
                        r_row   <= r_row + RAW'(1);
                        r_state <= Y_RSRD;
                    end
                end
                Y_FIND: begin
                    r_frow  <= find_row;
                    r_state <= Y_FW;
                end
                Y_FW: begin
                    r_any   <= |r_sum;
                    r_first <= (|r_sum) ? IW'({r_frow, find_bit}) : '0;
                    r_state <= Y_DONE;
                end
                default: begin
                    r_state <= Y_IDLE;
                end
            endcase
        end
    end

    assign o_sts   = '{done: (r_state == Y_DONE), old_bit: r_old, any: r_any};
    assign o_count = r_count;
    assign o_first = r_first;

endmodule

>>> rtl/gate_dependency_ready_tracker.sv
// Gate dependency ready tracker: top level with request sequencer and qubit table.
// Depends on gdrt_pkg, gdrt_gate_store, gdrt_ready and the assertion macro header.
//
// Usage:
//   Input channel i_valid/o_stall carries one request transaction (insert, resolve,
//   activate, restart). Output channel o_valid/i_stall returns exactly one result
//   transaction per request, in order. o_stall is high while a request is in work.
//   A rejected request goes straight to the result, as does a resolve of a finished
//   gate once its progress is read. An insert takes longer when the new gate has no
//   parent and enters the ready set; a resolve takes longer the more children are
//   counted down and turn ready. A restart clears the progress memory gate by gate,
//   then reloads the ready rows one by one and reports. Timing follows from the
//   single write port of each memory and the registered read of every
//   read-modify-write, done one step at a time.
//   A new request is taken while the previous result still waits in the output
//   register; a stalled result holds its value until taken, and the block waits
//   before loading the next one.
//   Reset clears the gate count, qubit table valid bits and ready set; per-gate
//   memories need no clearing since entries at or above the gate count are unused.
`include "gate_dependency_ready_tracker_assert.svh"
module gate_dependency_ready_tracker import gdrt_pkg::*; #(
    parameter int MAX_GATES  = DEF_MAX_GATES,
    parameter int MAX_QUBITS = DEF_MAX_QUBITS,
    parameter int KIND_BITS  = DEF_KIND_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ID_W-1:0]   i_gate_id,
    input  logic [KIND_W-1:0] i_gate_kind,
    input  logic              i_has_control,
    input  logic [QB_W-1:0]   i_control_qubit,
    input  logic [QB_W-1:0]   i_target_qubit,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ID_W-1:0]   o_assigned_id,
    output logic [ID_W-1:0]   o_new_ready_a,
    output logic              o_new_ready_a_valid,
    output logic [ID_W-1:0]   o_new_ready_b,
    output logic              o_new_ready_b_valid,
    output logic [CNT_W-1:0]  o_ready_count,
    output logic [ID_W-1:0]   o_first_ready_id,
    output logic              o_any_ready,
    output logic [KIND_W-1:0] o_out_gate_kind,
    output logic [CTL_W-1:0]  o_out_control,
    output logic [QB_W-1:0]   o_out_target,
    output logic [ST_W-1:0]   o_status
);

    localparam int IW  = $clog2(MAX_GATES);
    localparam int CW  = $clog2(MAX_GATES + 1);
    localparam int QW  = $clog2(MAX_QUBITS);
    localparam int CHW = IW + 1;
    localparam int OPW = 2 + KIND_BITS + 1 + 2 * QB_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_I0    = 4'd1;
    localparam logic [3:0] S_I1    = 4'd2;
    localparam logic [3:0] S_I2    = 4'd3;
    localparam logic [3:0] S_I3    = 4'd4;
    localparam logic [3:0] S_R0    = 4'd5;
    localparam logic [3:0] S_R1    = 4'd6;
    localparam logic [3:0] S_KRD   = 4'd7;
    localparam logic [3:0] S_KWR   = 4'd8;
    localparam logic [3:0] S_A0    = 4'd9;
    localparam logic [3:0] S_SWEEP = 4'd10;
    localparam logic [3:0] S_RWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [2:0] PH_ROOT  = 3'd0;
    localparam logic [2:0] PH_SELF  = 3'd1;
    localparam logic [2:0] PH_KID   = 3'd2;
    localparam logic [2:0] PH_ACT   = 3'd3;
    localparam logic [2:0] PH_RST   = 3'd4;

    // Qubit table: last gate and its role, valid bits in flops.
    logic [CHW-1:0]      q_mem [MAX_QUBITS];
    logic [MAX_QUBITS-1:0] r_qv;
    logic [CHW-1:0]      r_q_rdata;
    logic                q_re;
    logic [QW-1:0]       q_raddr;
    logic                q_we;
    logic [QW-1:0]       q_waddr;
    logic [CHW-1:0]      q_wdata;

    logic [3:0]          r_state;
    logic [2:0]          r_ph;
    logic [CW-1:0]       r_gate_count;
    logic [CW-1:0]       r_sw;
    logic                r_kidx;
    logic                r_ov;

    logic [ID_W-1:0]     r_gid;
    logic [KIND_BITS-1:0] r_kind;
    logic                r_hc;
    logic [QB_W-1:0]     r_cq;
    logic [QB_W-1:0]     r_tq;
    logic [IW-1:0]       r_id;
    logic                r_pc_v;
    logic                r_pc_ctl;
    logic [IW-1:0]       r_pc_id;
    logic                r_pt_v;
    logic                r_pt_ctl;
    logic [IW-1:0]       r_pt_id;
    logic [CHW-1:0]      r_c0;
    logic [CHW-1:0]      r_c1;

    // Result under construction.
    logic [ID_W-1:0]     r_asg;
    logic                r_na_v;
    logic [ID_W-1:0]     r_na;
    logic                r_nb_v;
    logic [ID_W-1:0]     r_nb;
    logic [KIND_W-1:0]   r_okind;
    logic [CTL_W-1:0]    r_octl;
    logic [QB_W-1:0]     r_otgt;
    logic [ST_W-1:0]     r_st;

    // Output register.
    logic [ID_W-1:0]     r_o_asg;
    logic                r_o_na_v;
    logic [ID_W-1:0]     r_o_na;
    logic                r_o_nb_v;
    logic [ID_W-1:0]     r_o_nb;
    logic [CNT_W-1:0]    r_o_cnt;
    logic [ID_W-1:0]     r_o_first;
    logic                r_o_any;
    logic [KIND_W-1:0]   r_o_kind;
    logic [CTL_W-1:0]    r_o_ctl;
    logic [QB_W-1:0]     r_o_tgt;
    logic [ST_W-1:0]     r_o_st;

    logic [3:0]          n_state;

    t_gs_ctl             gs_ctl;
    logic [IW-1:0]       gs_raddr;
    logic [IW-1:0]       cc_waddr;
    logic [CHW-1:0]      cc_wdata;
    logic [IW-1:0]       tc_waddr;
    logic [CHW-1:0]      tc_wdata;
    logic [IW-1:0]       pg_waddr;
    logic [2:0]          pg_wdata;
    logic [IW-1:0]       op_waddr;
    logic [OPW-1:0]      op_wdata;
    logic [CHW-1:0]      cc_rdata;
    logic [CHW-1:0]      tc_rdata;
    logic [2:0]          pg_rdata;
    logic [OPW-1:0]      op_rdata;

    t_rdy_cmd            rdy_cmd;
    logic [IW-1:0]       rdy_id;
    t_rdy_sts            rdy_sts;
    logic [CW-1:0]       rdy_count;
    logic [IW-1:0]       rdy_first;

    logic                w_accept;
    logic                w_out_load;
    logic                w_full;
    logic                w_bad_q;
    logic                w_bad_id;
    logic [1:0]          w_dep;
    logic                w_kid_v;
    logic [IW-1:0]       w_kid;
    logic [1:0]          w_pd_inc;
    logic [1:0]          w_kid_dep;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_out_load = (r_state == S_OUT) && (!r_ov || !i_stall);
    assign w_full     = (int'(r_gate_count) >= MAX_GATES);
    assign w_bad_q    = (int'(i_target_qubit) >= MAX_QUBITS) ||
                        (i_has_control && ((int'(i_control_qubit) >= MAX_QUBITS) ||
                                           (i_control_qubit == i_target_qubit)));
    assign w_bad_id   = (int'(i_gate_id) >= int'(r_gate_count));
    assign w_dep      = {1'b0, r_pc_v} + {1'b0, r_pt_v};
    assign w_kid_v    = r_kidx ? r_c1[IW] : r_c0[IW];
    assign w_kid      = r_kidx ? r_c1[IW-1:0] : r_c0[IW-1:0];
    assign w_pd_inc   = pg_rdata[2:1] + 2'd1;
    assign w_kid_dep  = op_rdata[OPW-1:OPW-2];

    gdrt_gate_store #(
        .MAX_GATES (MAX_GATES),
        .KIND_BITS (KIND_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_ctl      (gs_ctl),
        .i_raddr    (gs_raddr),
        .i_cc_waddr (cc_waddr),
        .i_cc_wdata (cc_wdata),
        .i_tc_waddr (tc_waddr),
        .i_tc_wdata (tc_wdata),
        .i_pg_waddr (pg_waddr),
        .i_pg_wdata (pg_wdata),
        .i_op_waddr (op_waddr),
        .i_op_wdata (op_wdata),
        .o_cc_rdata (cc_rdata),
        .o_tc_rdata (tc_rdata),
        .o_pg_rdata (pg_rdata),
        .o_op_rdata (op_rdata)
    );

    gdrt_ready #(
        .MAX_GATES (MAX_GATES)
    ) u_ready (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rdy_cmd),
        .i_id    (rdy_id),
        .o_sts   (rdy_sts),
        .o_count (rdy_count),
        .o_first (rdy_first)
    );

    // Memory strobes and ready-set commands for each step.
    always_comb begin
        gs_ctl   = '0;
        gs_raddr = IW'(r_gid);
        cc_waddr = r_id;
        cc_wdata = '0;
        tc_waddr = r_id;
        tc_wdata = '0;
        pg_waddr = r_id;
        pg_wdata = '0;
        op_waddr = r_id;
        op_wdata = {w_dep, r_kind, r_hc, r_cq, r_tq};
        q_re     = 1'b0;
        q_raddr  = QW'(r_cq);
        q_we     = 1'b0;
        q_waddr  = QW'(r_cq);
        q_wdata  = {1'b1, r_id};
        rdy_cmd  = '0;
        rdy_id   = r_id;
        case (r_state)
            S_I0: begin
                gs_ctl.cc_we = 1'b1;
                gs_ctl.tc_we = 1'b1;
                gs_ctl.pg_we = 1'b1;
                q_re         = 1'b1;
            end
            S_I1: begin
                q_re    = 1'b1;
                q_raddr = QW'(r_tq);
                q_we    = r_hc;
            end
            S_I2: begin
                q_we    = 1'b1;
                q_waddr = QW'(r_tq);
                q_wdata = {1'b0, r_id};
                if (r_pc_v) begin
                    gs_ctl.cc_we = r_pc_ctl;
                    gs_ctl.tc_we = !r_pc_ctl;
                    cc_waddr     = r_pc_id;
                    tc_waddr     = r_pc_id;
                    cc_wdata     = {1'b1, r_id};
                    tc_wdata     = {1'b1, r_id};
                end
            end
            S_I3: begin
                gs_ctl.op_we = 1'b1;
                if (r_pt_v) begin
                    gs_ctl.cc_we = r_pt_ctl;
                    gs_ctl.tc_we = !r_pt_ctl;
                    cc_waddr     = r_pt_id;
                    tc_waddr     = r_pt_id;
                    cc_wdata     = {1'b1, r_id};
                    tc_wdata     = {1'b1, r_id};
                end
                if (w_dep == 2'd0) begin
                    rdy_cmd = '{req: 1'b1, op: RDY_ROOT};
                end
            end
            S_R0: begin
                gs_ctl.rd_en = 1'b1;
            end
            S_R1: begin
                if (!pg_rdata[0]) begin
                    gs_ctl.pg_we = 1'b1;
                    pg_waddr     = IW'(r_gid);
                    pg_wdata     = {pg_rdata[2:1], 1'b1};
                    rdy_cmd      = '{req: 1'b1, op: RDY_CLR};
                    rdy_id       = IW'(r_gid);
                end
            end
            S_KRD: begin
                gs_ctl.rd_en = w_kid_v;
                gs_raddr     = w_kid;
            end
            S_KWR: begin
                gs_ctl.pg_we = 1'b1;
                pg_waddr     = w_kid;
                pg_wdata     = {w_pd_inc, pg_rdata[0]};
                rdy_id       = w_kid;
                if (w_pd_inc == w_kid_dep) begin
                    rdy_cmd = '{req: 1'b1, op: RDY_SET};
                end
            end
            S_A0: begin
                gs_ctl.rd_en = 1'b1;
                rdy_cmd      = '{req: 1'b1, op: RDY_CLR};
                rdy_id       = IW'(r_gid);
            end
            S_SWEEP: begin
                pg_waddr = IW'(r_sw);
                if (r_sw < r_gate_count) begin
                    gs_ctl.pg_we = 1'b1;
                end else begin
                    rdy_cmd = '{req: 1'b1, op: RDY_RESTART};
                end
            end
            default: begin
            end
        endcase
    end

    // Qubit table memory.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_q_rdata <= q_mem[q_raddr];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_INSERT:   n_state = (w_full || w_bad_q) ? S_OUT : S_I0;
                        REQ_RESOLVE:  n_state = w_bad_id ? S_OUT : S_R0;
                        REQ_ACTIVATE: n_state = w_bad_id ? S_OUT : S_A0;
                        default:      n_state = S_SWEEP;
                    endcase
                end
            end
            S_I0:    n_state = S_I1;
            S_I1:    n_state = S_I2;
            S_I2:    n_state = S_I3;
            S_I3:    n_state = (w_dep == 2'd0) ? S_RWAIT : S_OUT;
            S_R0:    n_state = S_R1;
            S_R1:    n_state = pg_rdata[0] ? S_OUT : S_RWAIT;
            S_KRD: begin
                if (w_kid_v) begin
                    n_state = S_KWR;
                end else if (r_kidx) begin
                    n_state = S_OUT;
                end
            end
            S_KWR: begin
                if (w_pd_inc == w_kid_dep) begin
                    n_state = S_RWAIT;
                end else if (r_kidx) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_KRD;
                end
            end
            S_A0:    n_state = S_RWAIT;
            S_SWEEP: n_state = (r_sw < r_gate_count) ? S_SWEEP : S_RWAIT;
            S_RWAIT: begin
                if (rdy_sts.done) begin
                    case (r_ph)
                        PH_SELF: n_state = S_KRD;
                        PH_KID:  n_state = r_kidx ? S_OUT : S_KRD;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT:   n_state = w_out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gate_count <= '0;
            r_qv         <= '0;
            r_ov         <= 1'b0;
            r_kidx       <= 1'b0;
            r_sw         <= '0;
            r_ph         <= PH_ROOT;
        end else begin
            r_state <= n_state;
            // A new result takes precedence over the one being taken.
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_gid  <= i_gate_id;
                        r_kind <= KIND_BITS'(i_gate_kind);
                        r_hc   <= i_has_control;
                        r_cq   <= i_control_qubit;
                        r_tq   <= i_target_qubit;
                        r_id   <= IW'(r_gate_count);
                        r_sw   <= '0;
                        r_kidx <= 1'b0;
                        r_asg  <= '0;
                        r_na_v <= 1'b0;
                        r_na   <= '0;
                        r_nb_v <= 1'b0;
                        r_nb   <= '0;
                        r_okind <= '0;
                        r_octl <= '0;
                        r_otgt <= '0;
                        r_st   <= ST_OK;
                        case (i_req_type)
                            REQ_INSERT: begin
                                if (w_full) begin
                                    r_st <= ST_FULL;
                                end else if (w_bad_q) begin
                                    r_st <= ST_BAD;
                                end
                            end
                            REQ_RESOLVE, REQ_ACTIVATE: begin
                                if (w_bad_id) begin
                                    r_st <= ST_BAD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_I1: begin
                    r_pc_v   <= r_hc && r_qv[QW'(r_cq)];
                    r_pc_ctl <= r_q_rdata[IW];
                    r_pc_id  <= r_q_rdata[IW-1:0];
                    if (r_hc) begin
                        r_qv[QW'(r_cq)] <= 1'b1;
                    end
                end
                S_I2: begin
                    r_pt_v          <= r_qv[QW'(r_tq)];
                    r_pt_ctl        <= r_q_rdata[IW];
                    r_pt_id         <= r_q_rdata[IW-1:0];
                    r_qv[QW'(r_tq)] <= 1'b1;
                end
                S_I3: begin
                    r_gate_count <= r_gate_count + CW'(1);
                    r_asg        <= ID_W'(r_id);
                    r_ph         <= PH_ROOT;
                end
                S_R1: begin
                    if (pg_rdata[0]) begin
                        r_st <= ST_FINISHED;
                    end
                    r_c0 <= cc_rdata;
                    r_c1 <= tc_rdata;
                    r_ph <= PH_SELF;
                end
                S_KRD: begin
                    if (!w_kid_v) begin
                        r_kidx <= 1'b1;
                    end
                end
                S_KWR: begin
                    r_ph <= PH_KID;
                    if (w_pd_inc != w_kid_dep) begin
                        r_kidx <= 1'b1;
                    end
                end
                S_A0: begin
                    r_ph <= PH_ACT;
                end
                S_SWEEP: begin
                    r_ph <= PH_RST;
                    if (r_sw < r_gate_count) begin
                        r_sw <= r_sw + CW'(1);
                    end
                end
                S_RWAIT: begin
                    if (rdy_sts.done) begin
                        case (r_ph)
                            PH_ROOT: begin
                                if (!rdy_sts.old_bit) begin
                                    r_na_v <= 1'b1;
                                    r_na   <= ID_W'(r_id);
                                end
                            end
                            PH_SELF: begin
                                r_kidx <= 1'b0;
                            end
                            PH_KID: begin
                                r_kidx <= 1'b1;
                                if (!rdy_sts.old_bit) begin
                                    if (!r_na_v) begin
                                        r_na_v <= 1'b1;
                                        r_na   <= ID_W'(w_kid);
                                    end else begin
                                        r_nb_v <= 1'b1;
                                        r_nb   <= ID_W'(w_kid);
                                    end
                                end
                            end
                            PH_ACT: begin
                                if (rdy_sts.old_bit) begin
                                    r_okind <= KIND_W'(op_rdata[KIND_BITS+2*QB_W:2*QB_W+1]);
                                    r_octl  <= op_rdata[2*QB_W] ?
                                               {1'b0, op_rdata[2*QB_W-1:QB_W]} : NO_CONTROL;
                                    r_otgt  <= op_rdata[QB_W-1:0];
                                end else begin
                                    r_st <= ST_NOT_READY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_o_asg   <= r_asg;
                        r_o_na_v  <= r_na_v;
                        r_o_na    <= r_na;
                        r_o_nb_v  <= r_nb_v;
                        r_o_nb    <= r_nb;
                        r_o_cnt   <= CNT_W'(rdy_count);
                        r_o_first <= ID_W'(rdy_first);
                        r_o_any   <= rdy_sts.any;
                        r_o_kind  <= r_okind;
                        r_o_ctl   <= r_octl;
                        r_o_tgt   <= r_otgt;
                        r_o_st    <= r_st;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid             = r_ov;
    assign o_assigned_id       = r_o_asg;
    assign o_new_ready_a       = r_o_na;
    assign o_new_ready_a_valid = r_o_na_v;
    assign o_new_ready_b       = r_o_nb;
    assign o_new_ready_b_valid = r_o_nb_v;
    assign o_ready_count       = r_o_cnt;
    assign o_first_ready_id    = r_o_first;
    assign o_any_ready         = r_o_any;
    assign o_out_gate_kind     = r_o_kind;
    assign o_out_control       = r_o_ctl;
    assign o_out_target        = r_o_tgt;
    assign o_status            = r_o_st;

    // The ready set never holds more gates than have been inserted.
    `GDRT_ASSERT(a_ready_le_gates, rdy_count <= r_gate_count, "ready count exceeds gate count")
    // The gate table never grows past its depth.
    `GDRT_ASSERT(a_gates_le_max, int'(r_gate_count) <= MAX_GATES, "gate count past table depth")
    // Ready-set completions only arrive while the sequencer waits for one.
    `GDRT_ASSERT(a_done_in_wait, !rdy_sts.done || r_state == S_RWAIT, "stray ready-set completion")
    // A result load presents a valid transaction and frees the input side.
    `GDRT_ASSERT_NEXT(a_out_loaded, w_out_load, r_ov && r_state == S_IDLE, "result not presented")

endmodule
